@@ design/tvc_pkg.sv @@
// ----------------------------------------------------------------------------
// tvc_pkg
// Types and constants shared by the verdict cache modules.
// ----------------------------------------------------------------------------
package tvc_pkg;

   localparam int VERDICT_COUNT   = 8;
   localparam int MAX_TTL_SECONDS = 86400;
   localparam logic [23:0] TICKS_PER_SECOND = 24'd10000000;
   localparam logic [62:0] TIME_MAX = {63{1'b1}};
   localparam logic [8:0]  REMOVED_MAX = 9'd511;

   typedef enum logic [2:0] {
      OP_LOOKUP     = 3'd0,
      OP_INSERT     = 3'd1,
      OP_REMOVE     = 3'd2,
      OP_INVALIDATE = 3'd3,
      OP_SWEEP      = 3'd4,
      OP_CLEAR      = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_VERDICT = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      REG_ENABLE      = 1'b0,
      REG_DEFAULT_TTL = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_EXPIRY,
      ST_SCAN,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] volume_serial;
      logic [63:0] file_id;
      logic [63:0] file_size;
      logic [63:0] write_time;
      logic [7:0]  verdict;
      logic [7:0]  threat_score;
      logic [62:0] expiry;
      logic [31:0] hits;
   } entry_type;

   typedef struct packed {
      logic        enabled;
      logic [16:0] default_ttl;
   } cfg_type;

endpackage

@@ design/tvc_if.sv @@
// ----------------------------------------------------------------------------
// tvc_req_if / tvc_rsp_if
// Valid/ready channels for cache requests and results.
// ----------------------------------------------------------------------------
interface tvc_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic [31:0]        volume_serial;
   logic [63:0]        file_id;
   logic signed [63:0] file_size;
   logic signed [63:0] write_time;
   logic [7:0]         verdict;
   logic [7:0]         threat_score;
   logic [31:0]        ttl_seconds;
   logic [62:0]        now;

   modport source (output valid, op, volume_serial, file_id, file_size, write_time,
                   verdict, threat_score, ttl_seconds, now, input ready);
   modport sink   (input valid, op, volume_serial, file_id, file_size, write_time,
                   verdict, threat_score, ttl_seconds, now, output ready);
endinterface

interface tvc_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [7:0]  hit_verdict;
   logic [7:0]  hit_score;
   logic [31:0] hit_count;
   logic [1:0]  status;
   logic [8:0]  removed_count;

   modport source (output valid, found, hit_verdict, hit_score, hit_count, status,
                   removed_count, input ready);
   modport sink   (input valid, found, hit_verdict, hit_score, hit_count, status,
                   removed_count, output ready);
endinterface

@@ design/tvc_cell.sv @@
// ----------------------------------------------------------------------------
// tvc_cell
// One entry slot of the rotating entry ring.
// ----------------------------------------------------------------------------
module tvc_cell
   import tvc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type d,
   output entry_type q
);

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= d;
      end
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end
   end

   assign q = entry_ff;

endmodule

@@ design/tvc_csr.sv @@
// ----------------------------------------------------------------------------
// tvc_csr
// APB-style configuration registers: enable and default lifetime.
// ----------------------------------------------------------------------------
module tvc_csr
   import tvc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic        enabled_ff;
   logic [16:0] dttl_ff;
   logic        wr;

   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
         dttl_ff    <= 17'd300;
      end else if (wr) begin
         if (csr_paddr[2] == REG_ENABLE) begin
            enabled_ff <= csr_pwdata[0];
         end else begin
            dttl_ff <= csr_pwdata[16:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_ENABLE) begin
         csr_prdata = {31'd0, enabled_ff};
      end else begin
         csr_prdata = {15'd0, dttl_ff};
      end
   end

   assign csr_pready  = 1'b1;
   assign cfg.enabled     = enabled_ff;
   assign cfg.default_ttl = dttl_ff;

endmodule

@@ design/ttl_verdict_cache.sv @@
// ----------------------------------------------------------------------------
// ttl_verdict_cache
// Fully associative verdict cache with per-entry lifetime.
// ----------------------------------------------------------------------------
// Entries sit in a ring of CAPACITY cells that rotates by one slot per cycle
// during the scan and fill passes; the entry at the head passes a single
// compare and update unit. A request passes a prep and an expiry step, one
// full rotation of the ring, and a done state that posts the result, and for
// an insert of a new key a second rotation to fill the lowest free slot.
// Requests refused up front (bad verdict, cache disabled for a lookup or
// insert, full table, unknown op) go from the expiry step straight to done.
// One request is worked at a time; the result register lets the next request
// in while a result is still waiting.
module ttl_verdict_cache
   import tvc_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   tvc_req_if.sink     req_ch,
   tvc_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [IW-1:0] LAST_POS = IW'(CAPACITY - 1);

   cfg_type cfg;

   tvc_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   // entry ring
   entry_type cell_d [CAPACITY];
   entry_type cell_q [CAPACITY];
   entry_type proc;
   logic      shift;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == CAPACITY - 1) begin : g_tail
         assign cell_d[g] = proc;
      end else begin : g_mid
         assign cell_d[g] = cell_q[g+1];
      end
      tvc_cell u_cell (.clock, .reset, .shift, .d(cell_d[g]), .q(cell_q[g]));
   end

   state_type state_ff, state_in;
   op_type      op_ff;
   logic [31:0] vol_ff;
   logic [63:0] fid_ff, fsize_ff, wtime_ff;
   logic [7:0]  verdict_ff, score_ff;
   logic [31:0] ttl_ff;
   logic [62:0] now_ff;
   logic [40:0] prod_ff, prod_in;
   logic [62:0] exp_ff, exp_in;
   logic [IW-1:0] pos_ff, pos_in, free_idx_ff, free_idx_in;
   logic        free_ff, free_in, match_ff, match_in;
   logic [CW-1:0] live_ff, live_in, removed_ff, removed_in;
   logic        found_ff, found_in;
   logic [7:0]  hv_ff, hv_in, hs_ff, hs_in;
   logic [31:0] hc_ff, hc_in;
   status_type  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in, load_rsp;
   logic        accept;

   logic        rsp_found_ff;
   logic [7:0]  rsp_hv_ff, rsp_hs_ff;
   logic [31:0] rsp_hc_ff;
   logic [1:0]  rsp_status_ff;
   logic [8:0]  rsp_removed_ff;

   entry_type   head;
   logic        key_match, drop;
   logic [31:0] ttl_sel;
   logic [16:0] ttl_clamp;
   logic [63:0] exp_sum;

   assign head   = cell_q[0];
   assign accept = req_ch.valid && req_ch.ready;
   assign key_match = head.valid && head.volume_serial == vol_ff &&
                      head.file_id == fid_ff && head.file_size == fsize_ff &&
                      head.write_time == wtime_ff;

   always_comb begin
      ttl_sel = (ttl_ff == 32'd0) ? {15'd0, cfg.default_ttl} : ttl_ff;
      ttl_clamp = (ttl_sel > 32'(MAX_TTL_SECONDS)) ? 17'(MAX_TTL_SECONDS)
                                                   : ttl_sel[16:0];
      prod_in = 41'(ttl_clamp) * 41'(TICKS_PER_SECOND);
      exp_sum = {1'b0, now_ff} + 64'(prod_ff);
      exp_in  = exp_sum[63] ? TIME_MAX : exp_sum[62:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_type'(req_ch.op);
         vol_ff     <= req_ch.volume_serial;
         fid_ff     <= req_ch.file_id;
         fsize_ff   <= req_ch.file_size;
         wtime_ff   <= req_ch.write_time;
         verdict_ff <= req_ch.verdict;
         score_ff   <= req_ch.threat_score;
         ttl_ff     <= req_ch.ttl_seconds;
         now_ff     <= req_ch.now;
      end
      prod_ff     <= prod_in;
      exp_ff      <= (state_ff == ST_EXPIRY) ? exp_in : exp_ff;
      pos_ff      <= pos_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      match_ff    <= match_in;
      removed_ff  <= removed_in;
      found_ff    <= found_in;
      hv_ff       <= hv_in;
      hs_ff       <= hs_in;
      hc_ff       <= hc_in;
      status_ff   <= status_in;
      if (load_rsp) begin
         rsp_found_ff   <= found_ff;
         rsp_hv_ff      <= hv_ff;
         rsp_hs_ff      <= hs_ff;
         rsp_hc_ff      <= hc_ff;
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= (32'(removed_ff) > 32'(REMOVED_MAX)) ? REMOVED_MAX
                                                                : 9'(removed_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      live_in      = live_ff;
      pos_in       = pos_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      match_in     = match_ff;
      removed_in   = removed_ff;
      found_in     = found_ff;
      hv_in        = hv_ff;
      hs_in        = hs_ff;
      hc_in        = hc_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      load_rsp     = 1'b0;
      shift        = 1'b0;
      proc         = head;
      drop         = 1'b0;
      req_ch.ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in    = ST_PREP;
               pos_in      = '0;
               free_in     = 1'b0;
               free_idx_in = '0;
               match_in    = 1'b0;
               removed_in  = '0;
               found_in    = 1'b0;
               hv_in       = '0;
               hs_in       = '0;
               hc_in       = '0;
               status_in   = STATUS_OK;
            end
         end
         ST_PREP: begin
            state_in = ST_EXPIRY;
         end
         ST_EXPIRY: begin
            state_in = ST_SCAN;
            case (op_ff)
               OP_LOOKUP: begin
                  if (!cfg.enabled) begin
                     state_in = ST_DONE;
                  end
               end
               OP_INSERT: begin
                  if (32'(verdict_ff) >= 32'(VERDICT_COUNT)) begin
                     status_in = STATUS_VERDICT;
                     state_in  = ST_DONE;
                  end else if (!cfg.enabled) begin
                     state_in = ST_DONE;
                  end else if (32'(live_ff) >= 32'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end
               end
               OP_REMOVE, OP_INVALIDATE, OP_SWEEP, OP_CLEAR: begin
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SCAN: begin
            shift = 1'b1;
            case (op_ff)
               OP_LOOKUP: begin
                  if (key_match && !found_ff && now_ff < head.expiry) begin
                     proc.hits = head.hits + 32'd1;
                     found_in  = 1'b1;
                     hv_in     = head.verdict;
                     hs_in     = head.threat_score;
                     hc_in     = head.hits + 32'd1;
                  end
               end
               OP_INSERT: begin
                  if (key_match && !match_ff) begin
                     proc.verdict      = verdict_ff;
                     proc.threat_score = score_ff;
                     proc.expiry       = exp_ff;
                     match_in          = 1'b1;
                  end
                  if (!head.valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = pos_ff;
                  end
               end
               OP_REMOVE: begin
                  if (key_match && !found_ff) begin
                     proc.valid = 1'b0;
                     found_in   = 1'b1;
                     if (live_ff != '0) begin
                        live_in = live_ff - CW'(1);
                     end
                  end
               end
               OP_INVALIDATE, OP_SWEEP, OP_CLEAR: begin
                  if (op_ff == OP_INVALIDATE) begin
                     drop = head.valid && head.volume_serial == vol_ff;
                  end else if (op_ff == OP_SWEEP) begin
                     drop = head.valid && now_ff >= head.expiry;
                  end else begin
                     drop = head.valid;
                  end
                  if (drop) begin
                     proc.valid = 1'b0;
                     removed_in = removed_ff + CW'(1);
                     if (live_ff != '0) begin
                        live_in = live_ff - CW'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
            pos_in = pos_ff + IW'(1);
            if (pos_ff == LAST_POS) begin
               pos_in   = '0;
               state_in = ST_DONE;
               if (op_ff == OP_CLEAR) begin
                  live_in = '0;
               end
               if (op_ff == OP_INSERT && !match_in) begin
                  if (free_in) begin
                     state_in = ST_FILL;
                  end else begin
                     status_in = STATUS_FULL;
                  end
               end
            end
         end
         ST_FILL: begin
            shift = 1'b1;
            if (pos_ff == free_idx_ff) begin
               proc.valid         = 1'b1;
               proc.volume_serial = vol_ff;
               proc.file_id       = fid_ff;
               proc.file_size     = fsize_ff;
               proc.write_time    = wtime_ff;
               proc.verdict       = verdict_ff;
               proc.threat_score  = score_ff;
               proc.expiry        = exp_ff;
               proc.hits          = '0;
               live_in            = live_ff + CW'(1);
            end
            pos_in = pos_ff + IW'(1);
            if (pos_ff == LAST_POS) begin
               pos_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.found         = rsp_found_ff;
   assign rsp_ch.hit_verdict   = rsp_hv_ff;
   assign rsp_ch.hit_score     = rsp_hs_ff;
   assign rsp_ch.hit_count     = rsp_hc_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.removed_count = rsp_removed_ff;

endmodule
